// File: hdl/fpba_pkg.sv
// Shared definitions for the first-press buzzer arbiter.
// Holds codes, register indexes and reset constants; depends on nothing.
package fpba_pkg;

    localparam int unsigned TEAMS_DEFAULT     = 10;
    localparam int unsigned RESPONSES_DEFAULT = 10;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] SILENCE_LIMIT_DEFAULT = 32'd5000;
    localparam logic [31:0] COOLDOWN_DEFAULT      = 32'd1000;
    localparam logic [31:0] DEBOUNCE_DEFAULT      = 32'd100;

    localparam logic [1:0] ZONE_YELLOW = 2'd1;
    localparam logic [1:0] ZONE_GREEN  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_LIMIT  = 2'd0,
        CFG_RESET_COOLDOWN = 2'd1,
        CFG_RESET_DEBOUNCE = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        MODE_PACKET = 3'd0,
        MODE_RESET  = 3'd1,
        MODE_SCAN   = 3'd2,
        MODE_POWER  = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_WINNER    = 4'd0,
        ST_LOGGED    = 4'd1,
        ST_REPEAT    = 4'd2,
        ST_LISTEN    = 4'd3,
        ST_HEARTBEAT = 4'd4,
        ST_BAD_ID    = 4'd5,
        ST_DISABLED  = 4'd6,
        ST_RESET     = 4'd7,
        ST_DROPPED   = 4'd8,
        ST_SCAN      = 4'd9,
        ST_POWER     = 4'd10,
        ST_READ      = 4'd11
    } t_status;

endpackage

// File: hdl/first_press_buzzer_arbiter.sv
// Top level of the first-press buzzer arbiter: round state, team presence,
// response order and the output register with its skid stage.
// Depends on fpba_pkg.

// One word per cycle while o_stall is low: every input word (team packet,
// reset press, timeout scan, power switch or order read) is resolved in the
// cycle it is accepted by a single pass of logic over the round and team
// registers, and its result word is registered. Back-to-back words are taken
// at full rate. The result side is an output register backed by a one-word
// skid stage, so o_stall is a registered flag that rises only when both hold
// a word; a stalled consumer costs at most one extra word of buffering before
// the input side stalls. Per-team timeout checks and the connected and red
// battery counts run in parallel over all TEAMS registers. Configuration
// writes take effect on the next clock edge and must be issued while the
// block is idle. Time differences wrap modulo 2^32.
module first_press_buzzer_arbiter
    import fpba_pkg::*;
#(
    parameter int unsigned TEAMS     = TEAMS_DEFAULT,
    parameter int unsigned RESPONSES = RESPONSES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_mode,
    input  logic [31:0]           i_now_ms,
    input  logic [31:0]           i_now_us,
    input  logic [3:0]            i_team_id,
    input  logic                  i_button_pressed,
    input  logic                  i_is_heartbeat,
    input  logic [1:0]            i_battery_zone,
    input  logic                  i_switch_on,
    input  logic [3:0]            i_entry_index,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_status,
    output logic                  o_quiz_active,
    output logic [3:0]            o_winner_team,
    output logic [31:0]           o_winner_time_us,
    output logic [3:0]            o_response_position,
    output logic [3:0]            o_response_count,
    output logic [TEAMS-1:0]      o_connected_mask,
    output logic [3:0]            o_connected_count,
    output logic [3:0]            o_red_battery_count,
    output logic [3:0]            o_entry_team,
    output logic [31:0]           o_entry_time_us
);

    localparam int unsigned TW = $clog2(TEAMS);
    localparam int unsigned RW = (RESPONSES > 1) ? $clog2(RESPONSES) : 1;

    typedef struct packed {
        t_status          status;
        logic             quiz_active;
        logic [3:0]       winner_team;
        logic [31:0]      winner_time_us;
        logic [3:0]       response_position;
        logic [3:0]       response_count;
        logic [TEAMS-1:0] connected_mask;
        logic [3:0]       connected_count;
        logic [3:0]       red_battery_count;
        logic [3:0]       entry_team;
        logic [31:0]      entry_time_us;
    } t_result;

    // Configuration registers
    logic [31:0] r_hb_timeout;
    logic [31:0] r_cooldown;
    logic [31:0] r_debounce;

    // Block and round state
    logic             r_on, n_on;
    logic             r_switch_seen, n_switch_seen;
    logic             r_ready, n_ready;
    logic [3:0]       r_winner_id, n_winner_id;
    logic [31:0]      r_winner_stamp, n_winner_stamp;
    logic [3:0]       r_logged, n_logged;
    logic [TEAMS-1:0] r_answered, n_answered;
    logic [TEAMS-1:0] r_online, n_online;
    logic [31:0]      r_last_edge, n_last_edge;
    logic [31:0]      r_last_reset, n_last_reset;

    // Per-team payload: only read while the team is online, so no reset
    logic [31:0] r_last_seen [TEAMS];
    logic [1:0]  r_zone      [TEAMS];

    // Response order: slots at or above r_logged read as empty
    logic [3:0]  r_order_team  [RESPONSES];
    logic [31:0] r_order_stamp [RESPONSES];

    // Output register and skid stage
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic          w_accept;
    logic          w_take;
    logic          w_touch;
    logic          w_log;
    logic [3:0]    w_team_m1;
    logic [TW-1:0] w_tidx;

    assign w_accept  = i_valid && !r_skid_valid;
    assign w_take    = r_out_valid && !i_stall;
    assign w_team_m1 = i_team_id - 4'd1;
    assign w_tidx    = w_team_m1[TW-1:0];

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_timeout <= SILENCE_LIMIT_DEFAULT;
            r_cooldown   <= COOLDOWN_DEFAULT;
            r_debounce   <= DEBOUNCE_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SILENCE_LIMIT:  r_hb_timeout <= i_cfg_data;
                CFG_RESET_COOLDOWN: r_cooldown   <= i_cfg_data;
                CFG_RESET_DEBOUNCE: r_debounce   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Resolve one word against the current state
    always_comb begin
        logic        team_ok;
        logic [RW-1:0] ridx;
        logic [3:0]  conn;
        logic [3:0]  red;
        logic [1:0]  zone;

        n_on           = r_on;
        n_switch_seen  = r_switch_seen;
        n_ready        = r_ready;
        n_winner_id    = r_winner_id;
        n_winner_stamp = r_winner_stamp;
        n_logged       = r_logged;
        n_answered     = r_answered;
        n_online       = r_online;
        n_last_edge    = r_last_edge;
        n_last_reset   = r_last_reset;
        w_touch        = 1'b0;
        w_log          = 1'b0;
        n_res          = '0;
        n_res.status   = ST_READ;

        team_ok = (i_team_id != 4'd0) && ({28'd0, i_team_id} <= 32'(TEAMS));
        ridx    = i_entry_index[RW-1:0];

        unique case (i_mode)
            MODE_PACKET: begin
                if (!r_on) begin
                    n_res.status = ST_DISABLED;
                end else if (!team_ok) begin
                    n_res.status = ST_BAD_ID;
                end else begin
                    // Refresh presence for any packet from a known team
                    w_touch          = 1'b1;
                    n_online[w_tidx] = 1'b1;
                    if (i_is_heartbeat || !i_button_pressed) begin
                        n_res.status = ST_HEARTBEAT;
                    end else if (!r_ready) begin
                        n_res.status = ST_LISTEN;
                    end else if (r_answered[w_tidx]) begin
                        n_res.status = ST_REPEAT;
                    end else begin
                        n_answered[w_tidx] = 1'b1;
                        n_res.status       = ST_LOGGED;
                        if (r_winner_id == 4'd0) begin
                            n_winner_id    = i_team_id;
                            n_winner_stamp = i_now_us;
                            n_res.status   = ST_WINNER;
                        end
                        if ({28'd0, r_logged} < 32'(RESPONSES)) begin
                            w_log                   = 1'b1;
                            n_logged                = r_logged + 4'd1;
                            n_res.response_position = r_logged + 4'd1;
                        end
                    end
                end
            end
            MODE_RESET: begin
                if ((i_now_ms - r_last_edge) > r_debounce) begin
                    n_last_edge = i_now_ms;
                    if (!r_on) begin
                        n_res.status = ST_DISABLED;
                    end else if ((i_now_ms - r_last_reset) < r_cooldown) begin
                        n_res.status = ST_DROPPED;
                    end else begin
                        // Toggle phase and clear the round
                        n_last_reset   = i_now_ms;
                        n_ready        = !r_ready;
                        n_winner_id    = 4'd0;
                        n_winner_stamp = 32'd0;
                        n_logged       = 4'd0;
                        n_answered     = '0;
                        n_res.status   = ST_RESET;
                    end
                end else begin
                    n_res.status = ST_DROPPED;
                end
            end
            MODE_SCAN: begin
                if (!r_on) begin
                    n_res.status = ST_DISABLED;
                end else begin
                    for (int i = 0; i < TEAMS; i++) begin
                        if (r_online[i] && ((i_now_ms - r_last_seen[i]) > r_hb_timeout)) begin
                            n_online[i] = 1'b0;
                        end
                    end
                    n_res.status = ST_SCAN;
                end
            end
            MODE_POWER: begin
                if (i_switch_on != r_switch_seen) begin
                    n_switch_seen = i_switch_on;
                    n_on          = i_switch_on;
                    if (i_switch_on) begin
                        n_ready = 1'b0;
                    end
                end
                n_res.status = ST_POWER;
            end
            MODE_READ: begin
                if (i_entry_index < r_logged) begin
                    n_res.entry_team    = r_order_team[ridx];
                    n_res.entry_time_us = r_order_stamp[ridx];
                end
                n_res.status = ST_READ;
            end
            default: ;
        endcase

        // Presence summary after the word; the sender's zone is the new one
        conn = 4'd0;
        red  = 4'd0;
        for (int i = 0; i < TEAMS; i++) begin
            zone = (w_touch && (w_tidx == TW'(i))) ? i_battery_zone : r_zone[i];
            if (n_online[i]) begin
                conn = conn + 4'd1;
                if ((zone != ZONE_YELLOW) && (zone != ZONE_GREEN)) begin
                    red = red + 4'd1;
                end
            end
        end

        n_res.quiz_active       = n_ready;
        n_res.winner_team       = n_winner_id;
        n_res.winner_time_us    = n_winner_stamp;
        n_res.response_count    = n_logged;
        n_res.connected_mask    = n_online;
        n_res.connected_count   = conn;
        n_res.red_battery_count = red;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on           <= 1'b0;
            r_switch_seen  <= 1'b0;
            r_ready        <= 1'b0;
            r_winner_id    <= 4'd0;
            r_winner_stamp <= 32'd0;
            r_logged       <= 4'd0;
            r_answered     <= '0;
            r_online       <= '0;
            r_last_edge    <= 32'd0;
            r_last_reset   <= 32'd0;
        end else if (w_accept) begin
            r_on           <= n_on;
            r_switch_seen  <= n_switch_seen;
            r_ready        <= n_ready;
            r_winner_id    <= n_winner_id;
            r_winner_stamp <= n_winner_stamp;
            r_logged       <= n_logged;
            r_answered     <= n_answered;
            r_online       <= n_online;
            r_last_edge    <= n_last_edge;
            r_last_reset   <= n_last_reset;
        end
    end

    // Per-team and order payload stores
    always_ff @(posedge i_clk) begin
        if (w_accept && w_touch) begin
            r_last_seen[w_tidx] <= i_now_ms;
            r_zone[w_tidx]      <= i_battery_zone;
        end
        if (w_accept && w_log) begin
            r_order_team[r_logged[RW-1:0]]  <= i_team_id;
            r_order_stamp[r_logged[RW-1:0]] <= i_now_us;
        end
    end

    // Output register and skid: park a new word if blocked, else drain on take.
    // An accept implies an empty skid, so the two arms never overlap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
        if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_stall             = r_skid_valid;
    assign o_valid             = r_out_valid;
    assign o_status            = r_out.status;
    assign o_quiz_active       = r_out.quiz_active;
    assign o_winner_team       = r_out.winner_team;
    assign o_winner_time_us    = r_out.winner_time_us;
    assign o_response_position = r_out.response_position;
    assign o_response_count    = r_out.response_count;
    assign o_connected_mask    = r_out.connected_mask;
    assign o_connected_count   = r_out.connected_count;
    assign o_red_battery_count = r_out.red_battery_count;
    assign o_entry_team        = r_out.entry_team;
    assign o_entry_time_us     = r_out.entry_time_us;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted word produced no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {28'd0, r_logged} <= 32'(RESPONSES))
        else $error("response count beyond order depth");

    a_no_winner_no_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_winner_id == 4'd0) |-> ((r_logged == 4'd0) && (r_answered == '0)))
        else $error("presses logged without a winner");

    a_logged_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_answered)) >= {28'd0, r_logged})
        else $error("more logged presses than answered teams");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking bench for first_press_buzzer_arbiter: directed and random words,
// random idling on both channels, a predictor that follows every accepted word.
// Depends on fpba_pkg and the arbiter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;

    localparam int unsigned TEAMS          = TEAMS_DEFAULT;
    localparam int unsigned RESPONSES      = RESPONSES_DEFAULT;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    // Codes outside the package lists: the unused register slot and the
    // undefined modes, which must answer like a read of nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE    = 2'd3;
    localparam logic [2:0]           MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0]           MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] now_us;
        logic [3:0]  team_id;
        logic        button_pressed;
        logic        is_heartbeat;
        logic [1:0]  battery_zone;
        logic        switch_on;
        logic [3:0]  entry_index;
    } t_buzz_word;

    typedef struct packed {
        logic [3:0]       status;
        logic             quiz_active;
        logic [3:0]       winner_team;
        logic [31:0]      winner_time_us;
        logic [3:0]       response_position;
        logic [3:0]       response_count;
        logic [TEAMS-1:0] connected_mask;
        logic [3:0]       connected_count;
        logic [3:0]       red_battery_count;
        logic [3:0]       entry_team;
        logic [31:0]      entry_time_us;
    } t_buzz_result;

    // ---------------------------------------------------------------------
    // DUT ports
    // ---------------------------------------------------------------------
    logic                  i_clk               = 1'b0;
    logic                  i_rst_n             = 1'b0;
    logic                  i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data          = '0;
    logic                  i_valid             = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_mode              = '0;
    logic [31:0]           i_now_ms            = '0;
    logic [31:0]           i_now_us            = '0;
    logic [3:0]            i_team_id           = '0;
    logic                  i_button_pressed    = 1'b0;
    logic                  i_is_heartbeat      = 1'b0;
    logic [1:0]            i_battery_zone      = '0;
    logic                  i_switch_on         = 1'b0;
    logic [3:0]            i_entry_index       = '0;
    logic                  o_valid;
    logic                  i_stall             = 1'b0;
    logic [3:0]            o_status;
    logic                  o_quiz_active;
    logic [3:0]            o_winner_team;
    logic [31:0]           o_winner_time_us;
    logic [3:0]            o_response_position;
    logic [3:0]            o_response_count;
    logic [TEAMS-1:0]      o_connected_mask;
    logic [3:0]            o_connected_count;
    logic [3:0]            o_red_battery_count;
    logic [3:0]            o_entry_team;
    logic [31:0]           o_entry_time_us;

    first_press_buzzer_arbiter dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Bench state
    // ---------------------------------------------------------------------
    t_buzz_word   queued_words[$];     // words waiting for the driver
    t_buzz_result pending_outcomes[$]; // predicted results, oldest first
    t_buzz_word   offered_word;        // word currently on the input port

    int unsigned mismatch_count = 0;
    int unsigned tx_gap_max     = 0;   // per-phase idling ranges, 0 = no idling
    int unsigned rx_gap_max     = 0;
    int unsigned tx_wait        = 0;
    int unsigned rx_wait        = 0;
    int unsigned hold_requests  = 0;   // raised by the sequencer, served by the receiver
    int unsigned hold_served    = 0;
    int unsigned rx_hold        = 0;
    int unsigned quiet_cycles   = 0;
    logic [31:0] gen_ms         = 32'd3000; // stimulus millisecond clock

    // ---------------------------------------------------------------------
    // Predictor state: registers, round, team table and response order
    // ---------------------------------------------------------------------
    logic [31:0] timeout_ms, cooldown_ms, debounce_ms;
    logic        powered, switch_level, quiz_ready;
    logic [3:0]  win_team;
    logic [31:0] win_us;
    logic [3:0]  order_len;
    logic        team_answered [TEAMS];
    logic        team_online   [TEAMS];
    logic [31:0] team_seen_ms  [TEAMS];
    logic [1:0]  team_zone     [TEAMS];
    logic [3:0]  order_team    [RESPONSES];
    logic [31:0] order_us      [RESPONSES];
    logic [31:0] press_seen_ms, reset_done_ms;

    function automatic void clear_round();
        win_team  = '0;
        win_us    = '0;
        order_len = '0;
        for (int i = 0; i < TEAMS; i++) team_answered[i] = 1'b0;
        for (int i = 0; i < RESPONSES; i++) begin
            order_team[i] = '0;
            order_us[i]   = '0;
        end
    endfunction

    function automatic void power_up_model();
        timeout_ms    = SILENCE_LIMIT_DEFAULT;
        cooldown_ms   = COOLDOWN_DEFAULT;
        debounce_ms   = DEBOUNCE_DEFAULT;
        powered       = 1'b0;
        switch_level  = 1'b0;
        quiz_ready    = 1'b0;
        press_seen_ms = '0;
        reset_done_ms = '0;
        clear_round();
        for (int i = 0; i < TEAMS; i++) begin
            team_online[i]  = 1'b0;
            team_seen_ms[i] = '0;
            team_zone[i]    = ZONE_GREEN;
        end
    endfunction

    // Advance the predictor by one accepted word and return its result.
    function automatic t_buzz_result resolve_word(t_buzz_word w);
        t_buzz_result r;
        int unsigned  slot;
        logic [31:0]  gap;
        r = '0;
        r.status = ST_READ;
        case (w.mode)
            MODE_PACKET: begin
                if (!powered) begin
                    r.status = ST_DISABLED;
                end else if (w.team_id == 0 || w.team_id > TEAMS) begin
                    r.status = ST_BAD_ID;
                end else begin
                    // Any packet from a real team refreshes its presence.
                    slot = w.team_id - 1;
                    team_seen_ms[slot] = w.now_ms;
                    team_zone[slot]    = w.battery_zone;
                    team_online[slot]  = 1'b1;
                    if (w.is_heartbeat || !w.button_pressed) begin
                        r.status = ST_HEARTBEAT;
                    end else if (!quiz_ready) begin
                        r.status = ST_LISTEN;
                    end else if (team_answered[slot]) begin
                        r.status = ST_REPEAT;
                    end else begin
                        team_answered[slot] = 1'b1;
                        r.status = ST_LOGGED;
                        if (win_team == 0) begin
                            win_team = w.team_id;
                            win_us   = w.now_us;
                            r.status = ST_WINNER;
                        end
                        // A full order still lets the press count, just unlogged.
                        if (order_len < RESPONSES) begin
                            order_team[order_len] = w.team_id;
                            order_us[order_len]   = w.now_us;
                            order_len = order_len + 1'b1;
                            r.response_position = order_len;
                        end
                    end
                end
            end
            MODE_RESET: begin
                gap = w.now_ms - press_seen_ms;
                if (gap > debounce_ms) begin
                    // The edge counts even when the block is off; it is then answered as disabled.
                    press_seen_ms = w.now_ms;
                    gap = w.now_ms - reset_done_ms;
                    if (!powered) begin
                        r.status = ST_DISABLED;
                    end else if (gap < cooldown_ms) begin
                        r.status = ST_DROPPED;
                    end else begin
                        reset_done_ms = w.now_ms;
                        quiz_ready    = !quiz_ready;
                        clear_round();
                        r.status = ST_RESET;
                    end
                end else begin
                    r.status = ST_DROPPED;
                end
            end
            MODE_SCAN: begin
                if (!powered) begin
                    r.status = ST_DISABLED;
                end else begin
                    for (int i = 0; i < TEAMS; i++) begin
                        gap = w.now_ms - team_seen_ms[i];
                        if (team_online[i] && gap > timeout_ms) team_online[i] = 1'b0;
                    end
                    r.status = ST_SCAN;
                end
            end
            MODE_POWER: begin
                // Turning on enters the listen phase but keeps the round.
                if (w.switch_on != switch_level) begin
                    switch_level = w.switch_on;
                    powered      = w.switch_on;
                    if (w.switch_on) quiz_ready = 1'b0;
                end
                r.status = ST_POWER;
            end
            MODE_READ: begin
                if (w.entry_index < RESPONSES) begin
                    r.entry_team    = order_team[w.entry_index];
                    r.entry_time_us = order_us[w.entry_index];
                end
            end
            default: ;
        endcase

        for (int i = 0; i < TEAMS; i++) begin
            if (team_online[i]) begin
                r.connected_mask[i] = 1'b1;
                r.connected_count   = r.connected_count + 1'b1;
                if (team_zone[i] != ZONE_YELLOW && team_zone[i] != ZONE_GREEN)
                    r.red_battery_count = r.red_battery_count + 1'b1;
            end
        end
        r.quiz_active    = quiz_ready;
        r.winner_team    = win_team;
        r.winner_time_us = win_us;
        r.response_count = order_len;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------
    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_buzz_result got, input t_buzz_result want);
        if (got.status !== want.status)
            log_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.quiz_active !== want.quiz_active)
            log_mismatch("quiz_active", 32'(got.quiz_active), 32'(want.quiz_active));
        if (got.winner_team !== want.winner_team)
            log_mismatch("winner_team", 32'(got.winner_team), 32'(want.winner_team));
        if (got.winner_time_us !== want.winner_time_us)
            log_mismatch("winner_time_us", got.winner_time_us, want.winner_time_us);
        if (got.response_position !== want.response_position)
            log_mismatch("response_position", 32'(got.response_position),
                         32'(want.response_position));
        if (got.response_count !== want.response_count)
            log_mismatch("response_count", 32'(got.response_count),
                         32'(want.response_count));
        if (got.connected_mask !== want.connected_mask)
            log_mismatch("connected_mask", 32'(got.connected_mask),
                         32'(want.connected_mask));
        if (got.connected_count !== want.connected_count)
            log_mismatch("connected_count", 32'(got.connected_count),
                         32'(want.connected_count));
        if (got.red_battery_count !== want.red_battery_count)
            log_mismatch("red_battery_count", 32'(got.red_battery_count),
                         32'(want.red_battery_count));
        if (got.entry_team !== want.entry_team)
            log_mismatch("entry_team", 32'(got.entry_team), 32'(want.entry_team));
        if (got.entry_time_us !== want.entry_time_us)
            log_mismatch("entry_time_us", got.entry_time_us, want.entry_time_us);
    endtask

    // ---------------------------------------------------------------------
    // Driver: offer queued words, predict each one at the edge it is taken
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : word_driver
        logic offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                pending_outcomes.push_back(resolve_word(offered_word));
                offer = 1'b0;
            end
            // Hold a stalled word as it is; otherwise count down the gap, then load.
            if (!offer) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (queued_words.size() > 0) begin
                    offered_word     = queued_words.pop_front();
                    i_mode           <= offered_word.mode;
                    i_now_ms         <= offered_word.now_ms;
                    i_now_us         <= offered_word.now_us;
                    i_team_id        <= offered_word.team_id;
                    i_button_pressed <= offered_word.button_pressed;
                    i_is_heartbeat   <= offered_word.is_heartbeat;
                    i_battery_zone   <= offered_word.battery_zone;
                    i_switch_on      <= offered_word.switch_on;
                    i_entry_index    <= offered_word.entry_index;
                    offer   = 1'b1;
                    tx_wait = $urandom_range(0, tx_gap_max);
                end
            end
            i_valid <= offer;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: take result words, compare with the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_buzz_result seen;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                seen.status            = o_status;
                seen.quiz_active       = o_quiz_active;
                seen.winner_team       = o_winner_team;
                seen.winner_time_us    = o_winner_time_us;
                seen.response_position = o_response_position;
                seen.response_count    = o_response_count;
                seen.connected_mask    = o_connected_mask;
                seen.connected_count   = o_connected_count;
                seen.red_battery_count = o_red_battery_count;
                seen.entry_team        = o_entry_team;
                seen.entry_time_us     = o_entry_time_us;
                if (pending_outcomes.size() == 0)
                    log_mismatch("result with nothing expected, status",
                                 32'(o_status), 32'(0));
                else
                    check_result(seen, pending_outcomes.pop_front());
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            // A long hold-off lets the skid stage fill and back-pressure the input.
            if (hold_served != hold_requests) begin
                hold_served++;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // End the run when no word moves on either side for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    function automatic void push_word(input logic [2:0] mode, input logic [31:0] ms,
                                      input logic [31:0] us, input logic [3:0] team,
                                      input logic pressed, input logic heartbeat,
                                      input logic [1:0] zone, input logic sw,
                                      input logic [3:0] idx);
        t_buzz_word w;
        w.mode           = mode;
        w.now_ms         = ms;
        w.now_us         = us;
        w.team_id        = team;
        w.button_pressed = pressed;
        w.is_heartbeat   = heartbeat;
        w.battery_zone   = zone;
        w.switch_on      = sw;
        w.entry_index    = idx;
        queued_words.push_back(w);
    endfunction

    // Mostly well-formed play: presses from real teams against a steadily
    // advancing clock, with resets spaced to pass the filters about half
    // the time. Mix in bad ids, clock jumps and undefined modes.
    task automatic queue_random(input int unsigned count);
        int unsigned pick, jump, k;
        logic [3:0]  team;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            jump = $urandom_range(0, 99);
            if (jump < 3)
                gen_ms = $urandom;
            else if (jump < 10)
                gen_ms += $urandom_range(1000, 7000);
            else
                gen_ms += $urandom_range(0, 60);
            if ($urandom_range(0, 9) == 0)
                team = 4'($urandom_range(0, 15));
            else
                team = 4'($urandom_range(1, TEAMS));
            if (pick < 60) begin
                push_word(MODE_PACKET, gen_ms, $urandom, team,
                          1'($urandom_range(0, 4) != 0), 1'($urandom_range(0, 6) == 0),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)));
            end else if (pick < 67) begin
                gen_ms += $urandom_range(0, 1500);
                push_word(MODE_RESET, gen_ms, $urandom, team, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end else if (pick < 75) begin
                push_word(MODE_SCAN, gen_ms, $urandom, team, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end else if (pick < 79) begin
                push_word(MODE_POWER, gen_ms, $urandom, team, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 5) != 0), 4'($urandom_range(0, 15)));
            end else if (pick < 95) begin
                push_word(MODE_READ, gen_ms, $urandom, team, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end else begin
                push_word(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), $urandom,
                          $urandom, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    // Block until every queued word is taken and every result has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_words.size() != 0 || i_valid || pending_outcomes.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_SILENCE_LIMIT:  timeout_ms  = value;
            CFG_RESET_COOLDOWN: cooldown_ms = value;
            CFG_RESET_DEBOUNCE: debounce_ms = value;
            default: ;
        endcase
    endtask

    // Drain, rewrite every register (plus the unused slot), set idling ranges.
    task automatic configure(input logic [31:0] timeout, input logic [31:0] cooldown,
                             input logic [31:0] debounce, input int unsigned tx_max,
                             input int unsigned rx_max);
        wait_idle();
        write_register(CFG_SILENCE_LIMIT, timeout);
        write_register(CFG_RESET_COOLDOWN, cooldown);
        write_register(CFG_RESET_DEBOUNCE, debounce);
        write_register(CFG_IDX_SPARE, $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
    endtask

    initial begin
        power_up_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset register values.
        configure(SILENCE_LIMIT_DEFAULT, COOLDOWN_DEFAULT, DEBOUNCE_DEFAULT, 18, 18);
        // Block off: packet, scan and a reset edge that still arms the debounce.
        push_word(MODE_PACKET, 32'd10, 32'd1, 4'd1, 1'b1, 1'b0, 2'd2, 1'b0, 4'd0);
        push_word(MODE_SCAN, 32'd20, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        push_word(MODE_RESET, 32'd200, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        // Switch unchanged, on, unchanged.
        push_word(MODE_POWER, 32'd210, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        push_word(MODE_POWER, 32'd220, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b1, 4'd0);
        push_word(MODE_POWER, 32'd230, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b1, 4'd0);
        // Bad ids at both ends, heartbeat with red zone, idle packet with zone 3,
        // press during listen.
        push_word(MODE_PACKET, 32'd240, 32'd5, 4'd0, 1'b1, 1'b0, 2'd2, 1'b0, 4'd0);
        push_word(MODE_PACKET, '1, '1, 4'd15, 1'b1, 1'b1, 2'd3, 1'b1, 4'd15);
        push_word(MODE_PACKET, 32'd300, 32'd7, 4'd3, 1'b1, 1'b1, 2'd0, 1'b0, 4'd0);
        push_word(MODE_PACKET, 32'd310, 32'd8, 4'd4, 1'b0, 1'b0, 2'd3, 1'b0, 4'd0);
        push_word(MODE_PACKET, 32'd320, 32'd9, 4'd5, 1'b1, 1'b0, 2'd1, 1'b0, 4'd0);
        // Reset inside the debounce window, then one that opens the round.
        push_word(MODE_RESET, 32'd250, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        push_word(MODE_RESET, 32'd2000, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        // Winner at the top stamp, a logged press at zero, a repeat.
        push_word(MODE_PACKET, 32'd2010, '1, 4'd10, 1'b1, 1'b0, 2'd2, 1'b0, 4'd0);
        push_word(MODE_PACKET, 32'd2020, 32'd0, 4'd1, 1'b1, 1'b0, 2'd1, 1'b0, 4'd0);
        push_word(MODE_PACKET, 32'd2030, 32'd3, 4'd10, 1'b1, 1'b0, 2'd2, 1'b0, 4'd0);
        // Reads in range and beyond the order, and an undefined mode.
        push_word(MODE_READ, 32'd2040, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        push_word(MODE_READ, 32'd2050, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd15);
        push_word(MODE_SPARE_LAST, '1, '1, 4'd15, 1'b1, 1'b1, 2'd3, 1'b1, 4'd15);
        // Reset that passes the debounce but not the cooldown.
        push_word(MODE_RESET, 32'd2500, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        // Power cycle: back to listen with the round kept.
        push_word(MODE_POWER, 32'd2600, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);
        push_word(MODE_POWER, 32'd2610, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b1, 4'd0);
        push_word(MODE_READ, 32'd2620, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd1);
        // Clock wrap: a team seen just below the wrap survives a scan just after it.
        push_word(MODE_PACKET, 32'hFFFF_FFF0, 32'd0, 4'd2, 1'b0, 1'b0, 2'd2, 1'b0, 4'd0);
        push_word(MODE_SCAN, 32'h0000_0010, 32'd0, 4'd0, 1'b0, 1'b0, 2'd0, 1'b0, 4'd0);

        // Random play across register settings and idling patterns.
        configure('0, '0, '0, 0, 0);
        queue_random(350);
        configure($urandom_range(200, 20000), $urandom_range(0, 3000),
                  $urandom_range(0, 300), 18, 0);
        queue_random(350);
        configure('1, '1, '1, 0, 18);
        queue_random(150);
        // Back-pressure: full-rate sender against a receiver that holds off.
        configure(SILENCE_LIMIT_DEFAULT, COOLDOWN_DEFAULT, DEBOUNCE_DEFAULT, 0, 0);
        hold_requests++;
        queue_random(300);
        configure($urandom_range(200, 20000), $urandom_range(0, 3000),
                  $urandom_range(0, 300), 3, 3);
        queue_random(300);
        configure($urandom_range(200, 20000), $urandom_range(0, 3000),
                  $urandom_range(0, 300), 18, 18);
        queue_random(300);

        // Drain, then give the output register and skid stage time to show
        // any stray word.
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: first_press_buzzer_arbiter.f
hdl/fpba_pkg.sv
hdl/first_press_buzzer_arbiter.sv
verif/tb_top.sv
